FILE: hdl/scpf_pkg.sv
package scpf_pkg;

  // Header layout and sequencer step numbers.
  localparam int unsigned HDR_BYTES = 13;
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_START = 4'd0;
  localparam logic [STEP_W-1:0] STEP_HEX3 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_HEX2 = 4'd2;
  localparam logic [STEP_W-1:0] STEP_HEX1 = 4'd3;
  localparam logic [STEP_W-1:0] STEP_HEX0 = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LEN_LO = 4'd5;
  localparam logic [STEP_W-1:0] STEP_LEN_HI = 4'd6;
  localparam logic [STEP_W-1:0] STEP_FIX_FF = 4'd7;
  localparam logic [STEP_W-1:0] STEP_FIX_02A = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SHORT_LEN = 4'd9;
  localparam logic [STEP_W-1:0] STEP_TYPE = 4'd10;
  localparam logic [STEP_W-1:0] STEP_FIX_80 = 4'd11;
  localparam logic [STEP_W-1:0] STEP_FIX_02B = 4'd12;
  localparam logic [STEP_W-1:0] STEP_DATA = 4'd13;
  localparam logic [STEP_W-1:0] STEP_END = 4'd14;

  // Fixed header constants.
  localparam logic [7:0] HDR_FF = 8'hFF;
  localparam logic [7:0] HDR_02 = 8'h02;
  localparam logic [7:0] HDR_80 = 8'h80;
  localparam logic [15:0] LEN_OFFSET = 16'd8;
  localparam logic [7:0] SHORT_OFFSET = 8'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 1'b1;
  localparam logic [7:0] START_MARKER_RST = 8'd64;
  localparam logic [7:0] END_MARKER_RST = 8'd10;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic [7:0]  ptype;
    logic [15:0] len;
    logic [7:0]  short_len;
    logic [7:0]  data;
    logic        has_header;
    logic        has_data;
    logic        has_end;
  } cmd_t;

  // Upper-case ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib < 4'd10) begin
      return wide + 8'h30;
    end else begin
      return wide + 8'h37;
    end
  endfunction

endpackage

FILE: hdl/scpf_if.sv
interface scpf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_type;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic        no_payload;

  modport source (output valid, msg_type, payload_length, data_byte, first_byte,
                  last_byte, no_payload, input ready);
  modport sink (input valid, msg_type, payload_length, data_byte, first_byte,
                last_byte, no_payload, output ready);
endinterface

interface scpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink (input valid, out_byte, frame_end, output ready);
endinterface

FILE: hdl/scpf_front.sv
module scpf_front (
  input  logic             clk,
  input  logic             rst,
  scpf_in_if.sink          din,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output scpf_pkg::cmd_t   cmd
);

  logic           held;
  scpf_pkg::cmd_t cmd_next;

  // The register is free when empty or when the queue takes its word.
  assign din.ready = !held || cmd_ready;
  assign cmd_valid = held;

  // Classify the incoming word into header, data and end actions.
  always_comb begin
    cmd_next.ptype = din.msg_type;
    cmd_next.data = din.data_byte;
    if (din.no_payload) begin
      cmd_next.len = scpf_pkg::LEN_OFFSET;
      cmd_next.short_len = scpf_pkg::SHORT_OFFSET;
      cmd_next.has_header = 1'b1;
      cmd_next.has_data = 1'b0;
      cmd_next.has_end = 1'b1;
    end else begin
      cmd_next.len = din.payload_length + scpf_pkg::LEN_OFFSET;
      cmd_next.short_len = din.payload_length[7:0] + scpf_pkg::SHORT_OFFSET;
      cmd_next.has_header = din.first_byte;
      cmd_next.has_data = 1'b1;
      cmd_next.has_end = din.last_byte;
    end
  end

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (din.ready) begin
      held <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

FILE: hdl/scpf_queue.sv
module scpf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  scpf_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output scpf_pkg::cmd_t pop_cmd
);

  scpf_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_cmd = entry[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // The fill count and the pointer distance must agree.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

FILE: hdl/scpf_back.sv
module scpf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  scpf_pkg::cmd_t                cmd,
  input  logic [7:0]                    start_marker,
  input  logic [7:0]                    end_marker,
  scpf_out_if.source                    dout
);

  logic                        mid;
  logic [scpf_pkg::STEP_W-1:0] step;
  logic [scpf_pkg::STEP_W-1:0] cur;
  logic [scpf_pkg::STEP_W-1:0] step_next;
  logic                        last;
  logic                        fire;
  logic                        ov;
  logic [7:0]                  obyte;
  logic                        oend;
  logic [7:0]                  byte_next;

  // Current step: the stored one mid-command, otherwise the command's first.
  always_comb begin
    if (mid) begin
      cur = step;
    end else if (cmd.has_header) begin
      cur = scpf_pkg::STEP_START;
    end else begin
      cur = scpf_pkg::STEP_DATA;
    end
  end

  // Following step and whether this byte closes the command.
  always_comb begin
    if (cur == scpf_pkg::STEP_FIX_02B) begin
      step_next = cmd.has_data ? scpf_pkg::STEP_DATA : scpf_pkg::STEP_END;
    end else begin
      step_next = cur + 4'd1;
    end
    last = (cur == scpf_pkg::STEP_END) || ((cur == scpf_pkg::STEP_DATA) && !cmd.has_end);
  end

  // Byte selection.
  always_comb begin
    case (cur)
      scpf_pkg::STEP_START:     byte_next = start_marker;
      scpf_pkg::STEP_HEX3:      byte_next = scpf_pkg::hex_digit(cmd.len[15:12]);
      scpf_pkg::STEP_HEX2:      byte_next = scpf_pkg::hex_digit(cmd.len[11:8]);
      scpf_pkg::STEP_HEX1:      byte_next = scpf_pkg::hex_digit(cmd.len[7:4]);
      scpf_pkg::STEP_HEX0:      byte_next = scpf_pkg::hex_digit(cmd.len[3:0]);
      scpf_pkg::STEP_LEN_LO:    byte_next = cmd.len[7:0];
      scpf_pkg::STEP_LEN_HI:    byte_next = cmd.len[15:8];
      scpf_pkg::STEP_FIX_FF:    byte_next = scpf_pkg::HDR_FF;
      scpf_pkg::STEP_FIX_02A:   byte_next = scpf_pkg::HDR_02;
      scpf_pkg::STEP_SHORT_LEN: byte_next = cmd.short_len;
      scpf_pkg::STEP_TYPE:      byte_next = cmd.ptype;
      scpf_pkg::STEP_FIX_80:    byte_next = scpf_pkg::HDR_80;
      scpf_pkg::STEP_FIX_02B:   byte_next = scpf_pkg::HDR_02;
      scpf_pkg::STEP_DATA:      byte_next = cmd.data;
      scpf_pkg::STEP_END:       byte_next = end_marker;
      default:                  byte_next = cmd.data;
    endcase
  end

  assign fire = cmd_valid && (!ov || dout.ready);
  assign cmd_ready = fire && last;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
      step <= scpf_pkg::STEP_START;
    end else if (fire) begin
      mid <= !last;
      step <= step_next;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (!ov || dout.ready) begin
      ov <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      obyte <= byte_next;
      oend <= (cur == scpf_pkg::STEP_END);
    end
  end

  assign dout.valid = ov;
  assign dout.out_byte = obyte;
  assign dout.frame_end = oend;

  // A command part-way through must still be at the queue head.
  a_mid_valid: assert property (@(posedge clk) disable iff (rst)
    mid |-> cmd_valid)
    else $error("sequencer lost its command");

  // The closing step always lands on a word marked as frame end.
  a_end_flag: assert property (@(posedge clk) disable iff (rst)
    (fire && cur == scpf_pkg::STEP_END) |=> (dout.valid && dout.frame_end))
    else $error("end step did not raise frame_end");

  // The end step only ever closes a command.
  a_end_pops: assert property (@(posedge clk) disable iff (rst)
    (fire && cur == scpf_pkg::STEP_END) |-> cmd_ready)
    else $error("end step did not release the command");

endmodule

FILE: hdl/sonar_command_packet_framer.sv
// Sonar command packet framer. Each input word carries one payload byte; a word
// marked first_byte is preceded by the 13-byte header (start marker, length as four
// hex digits, length little-endian, 0xFF, 0x02, short length, message type, 0x80,
// 0x02), and a word marked last_byte is followed by the end marker, flagged by
// frame_end. A no_payload word gives a header with zero payload and the end marker.
// The output sequencer sends one byte per cycle while the receiver is ready; a data
// word gives one byte, one with the end marker two, one with header 14, one with
// both 15, and a no-payload word 14. Words enter every cycle while the two-entry
// command queue has room and pass the front command register and the queue to the
// output byte register. The user must write the start and end markers through the
// configuration port only while the block is idle; the block does not enforce this.
module sonar_command_packet_framer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  scpf_in_if.sink                        din,
  scpf_out_if.source                     dout
);

  logic [7:0]     start_marker;
  logic [7:0]     end_marker;
  logic           f_valid;
  logic           f_ready;
  scpf_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_ready;
  scpf_pkg::cmd_t q_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= scpf_pkg::START_MARKER_RST;
      end_marker <= scpf_pkg::END_MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scpf_pkg::REG_START_MARKER: start_marker <= cfg_data;
        scpf_pkg::REG_END_MARKER:   end_marker <= cfg_data;
        default:                    start_marker <= start_marker;
      endcase
    end
  end

  scpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  scpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  scpf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd_ready    (q_ready),
    .cmd          (q_cmd),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .dout         (dout)
  );

endmodule

FILE: tb/scpf_frame_checker.sv
// Watches both channels of the packet framer, predicts the bytes of every accepted
// word and compares them, in order, with the words leaving the block.
module scpf_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  scpf_in_if                             din,
  scpf_out_if                            dout,
  output int                             errors,
  output int                             outstanding
);

  typedef struct packed {
    logic [7:0] value;
    logic       closing;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  logic [7:0]  start_mark;
  logic [7:0]  end_mark;

  // Upper-case ASCII character for one nibble of the length.
  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return "A" + 8'(nib - 4'd10);
    end
    return "0" + 8'(nib);
  endfunction

  function automatic void queue_byte(input logic [7:0] value, input logic closing);
    frame_byte_t fb;
    fb.value = value;
    fb.closing = closing;
    expected_bytes.push_back(fb);
  endfunction

  // The thirteen header bytes for a given payload count and message type.
  function automatic void queue_header(input logic [15:0] plen, input logic [7:0] ptype);
    logic [15:0] total;
    total = plen + scpf_pkg::LEN_OFFSET;
    queue_byte(start_mark, 1'b0);
    queue_byte(ascii_hex(total[15:12]), 1'b0);
    queue_byte(ascii_hex(total[11:8]), 1'b0);
    queue_byte(ascii_hex(total[7:4]), 1'b0);
    queue_byte(ascii_hex(total[3:0]), 1'b0);
    queue_byte(total[7:0], 1'b0);
    queue_byte(total[15:8], 1'b0);
    queue_byte(scpf_pkg::HDR_FF, 1'b0);
    queue_byte(scpf_pkg::HDR_02, 1'b0);
    queue_byte(plen[7:0] + scpf_pkg::SHORT_OFFSET, 1'b0);
    queue_byte(ptype, 1'b0);
    queue_byte(scpf_pkg::HDR_80, 1'b0);
    queue_byte(scpf_pkg::HDR_02, 1'b0);
  endfunction

  // Bytes that one accepted input word gives rise to.
  function automatic void frame_word();
    if (din.no_payload) begin
      queue_header(16'd0, din.msg_type);
      queue_byte(end_mark, 1'b1);
    end else begin
      if (din.first_byte) begin
        queue_header(din.payload_length, din.msg_type);
      end
      queue_byte(din.data_byte, 1'b0);
      if (din.last_byte) begin
        queue_byte(end_mark, 1'b1);
      end
    end
  endfunction

  // Track register writes, predict on input words and check output words.
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      start_mark = scpf_pkg::START_MARKER_RST;
      end_mark = scpf_pkg::END_MARKER_RST;
      errors = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == scpf_pkg::REG_START_MARKER) begin
          start_mark = cfg_data;
        end else if (cfg_index == scpf_pkg::REG_END_MARKER) begin
          end_mark = cfg_data;
        end
      end
      if (din.valid && din.ready) begin
        frame_word();
      end
      if (dout.valid && dout.ready) begin
        if (expected_bytes.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected word %02h frame_end %0b with nothing outstanding",
                     $realtime, dout.out_byte, dout.frame_end);
          end
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (dout.out_byte !== want.value || dout.frame_end !== want.closing) begin
            if (errors < 10) begin
              $display("%0t: out_byte expected %02h got %02h, frame_end expected %0b got %0b",
                       $realtime, want.value, dout.out_byte, want.closing, dout.frame_end);
            end
            errors++;
          end
        end
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

FILE: tb/sonar_command_packet_framer_tb.sv
// Stimulus and verdict for the sonar command packet framer.
module sonar_command_packet_framer_tb;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_data;
  int                             errors;
  int                             outstanding;
  int                             words_sent = 0;
  bit                             idle_on = 1'b1;
  bit                             hold_req = 1'b0;

  scpf_in_if  in_ch ();
  scpf_out_if out_ch ();

  sonar_command_packet_framer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (in_ch),
    .dout      (out_ch)
  );

  scpf_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .din         (in_ch),
    .dout        (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one input word, after an optional burst of idle cycles, and return on the
  // edge at which it is taken.
  task automatic offer_word(input logic [7:0] ptype, input logic [15:0] plen,
                            input logic [7:0] data, input logic first, input logic last,
                            input logic nopay);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.msg_type <= ptype;
    in_ch.payload_length <= plen;
    in_ch.data_byte <= data;
    in_ch.first_byte <= first;
    in_ch.last_byte <= last;
    in_ch.no_payload <= nopay;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // A well-formed packet of n words; fields that the block ignores get noise.
  task automatic send_packet(input int n, input logic [15:0] plen, input logic [7:0] ptype);
    for (int i = 0; i < n; i++) begin
      offer_word((i == 0) ? ptype : 8'($urandom), (i == 0) ? plen : 16'($urandom),
                 8'($urandom), i == 0, i == n - 1, 1'b0);
    end
  endtask

  // Stop offering and wait until every predicted byte has left the block.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [scpf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly whole packets with random content, some no-payload words and some stray
  // words with random flags.
  task automatic random_words(input int target);
    int pick;
    int n;
    logic [15:0] plen;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        offer_word(8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom), 1'b1);
      end else if (pick < 16) begin
        offer_word(8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        plen = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(n);
        send_packet(n, plen, 8'($urandom));
      end
    end
  endtask

  // Receiver: random ready bursts, and one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Main sequence of phases, each with its own marker setting.
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= scpf_pkg::REG_START_MARKER;
    cfg_data <= 8'd0;
    in_ch.valid <= 1'b0;
    in_ch.msg_type <= 8'd0;
    in_ch.payload_length <= 16'd0;
    in_ch.data_byte <= 8'd0;
    in_ch.first_byte <= 1'b0;
    in_ch.last_byte <= 1'b0;
    in_ch.no_payload <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // No-payload words: flags, length and data must all be ignored.
    offer_word(8'h00, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1);
    offer_word(8'hFF, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1);
    // Single-word packet and a three-word packet.
    offer_word(8'hA5, 16'd1, 8'h00, 1'b1, 1'b1, 1'b0);
    offer_word(8'h5A, 16'd3, 8'hFF, 1'b1, 1'b0, 1'b0);
    offer_word(8'h00, 16'hFFFF, 8'h5A, 1'b0, 1'b0, 1'b0);
    offer_word(8'hFF, 16'h1234, 8'hA5, 1'b0, 1'b1, 1'b0);
    // Largest legal payload count, then counts whose total wraps past 16 bits.
    offer_word(8'h01, 16'd65527, 8'h81, 1'b1, 1'b1, 1'b0);
    offer_word(8'h7F, 16'hFFFF, 8'h7E, 1'b1, 1'b1, 1'b0);
    offer_word(8'h80, 16'hFFF8, 8'h01, 1'b1, 1'b1, 1'b0);
    // Lengths whose hex digits cover every letter and the numerals 0-3 and 6-9.
    offer_word(8'h10, 16'hABC5, 8'h33, 1'b1, 1'b0, 1'b0);
    offer_word(8'h10, 16'h0000, 8'hCC, 1'b0, 1'b1, 1'b0);
    offer_word(8'h20, 16'h986E, 8'h44, 1'b1, 1'b1, 1'b0);
    offer_word(8'h30, 16'hFED4, 8'h55, 1'b1, 1'b1, 1'b0);
    offer_word(8'h40, 16'h011B, 8'h66, 1'b1, 1'b1, 1'b0);
    // Declared count that disagrees with the words actually sent.
    offer_word(8'h33, 16'd5, 8'h11, 1'b1, 1'b1, 1'b0);
    // Stray words outside any packet, and two first words in a row.
    offer_word(8'h44, 16'h0000, 8'h22, 1'b0, 1'b0, 1'b0);
    offer_word(8'h44, 16'h0000, 8'h23, 1'b0, 1'b1, 1'b0);
    offer_word(8'h55, 16'd2, 8'h24, 1'b1, 1'b0, 1'b0);
    offer_word(8'h66, 16'd1, 8'h25, 1'b1, 1'b1, 1'b0);
    random_words(130);
    drain();

    // Lowest start marker, highest end marker; the receiver holds off at first.
    write_reg(scpf_pkg::REG_START_MARKER, 8'h00);
    write_reg(scpf_pkg::REG_END_MARKER, 8'hFF);
    hold_req = 1'b1;
    send_packet(30, 16'd30, 8'hC3);
    random_words(240);
    drain();

    // Highest start marker, lowest end marker.
    write_reg(scpf_pkg::REG_START_MARKER, 8'hFF);
    write_reg(scpf_pkg::REG_END_MARKER, 8'h00);
    random_words(330);
    drain();

    // Random markers, and no idling on either side to finish.
    write_reg(scpf_pkg::REG_END_MARKER, 8'($urandom));
    write_reg(scpf_pkg::REG_START_MARKER, 8'($urandom));
    idle_on = 1'b0;
    random_words(420);
    drain();

    repeat (20) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
